@@ hw/rtl/htb_pkg.sv @@
// htb_pkg: shared types, character codes and result codes for the hex text decoder.
// Used by htb_decode, hex_text_to_bytes, htb_result_checker and testbench; depends on nothing else.
`timescale 1ns / 1ps

package htb_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;

  // characters that steer the parser
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_X      = 8'h78;  // 'x'
  localparam logic [7:0] CH_LBRACE = 8'h7B;  // '{'
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NON_HEX  = 3'd1;
  localparam logic [2:0] ERR_UNPAIRED = 3'd2;
  localparam logic [2:0] ERR_BRACE    = 3'd3;
  localparam logic [2:0] ERR_TRAILING = 3'd4;

  typedef enum logic [5:0] {
    PH_START        = 6'b000001,
    PH_SAW_ZERO     = 6'b000010,
    PH_AFTER_PREFIX = 6'b000100,
    PH_BODY         = 6'b001000,
    PH_CLOSED       = 6'b010000,
    PH_DROP         = 6'b100000
  } htb_phase_t;

  typedef struct packed {
    htb_phase_t  phase;
    logic        in_braces;
    logic        half_byte_pending;
    logic [3:0]  high_nibble;
  } htb_state_t;

  localparam htb_state_t STATE_RESET = '{
    phase:             PH_START,
    in_braces:         1'b0,
    half_byte_pending: 1'b0,
    high_nibble:       4'd0
  };

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } htb_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
    logic [2:0]  error_code;
  } htb_out_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'd0;
    r = 5'd0;
    case (c) inside
      [8'h30:8'h39]: begin
        d = c - 8'h30;
        r = {1'b1, d[3:0]};
      end
      [8'h61:8'h66]: begin
        d = c - 8'h57;
        r = {1'b1, d[3:0]};
      end
      [8'h41:8'h46]: begin
        d = c - 8'h37;
        r = {1'b1, d[3:0]};
      end
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/hex_text_to_bytes.sv @@
// hex_text_to_bytes: streaming hex text to byte decoder, top level.
// Depends on htb_pkg and htb_decode.
`timescale 1ns / 1ps

// Usage:
//   text channel (text_valid/text_ready/text) carries one ASCII character per
//   transaction, with end_of_text marking the string terminator (the character
//   is then ignored). An optional "0x" prefix and an optional {...} wrapper
//   are accepted around pairs of hex digits of either case.
//   result channel (result_valid/result_ready/result) carries a decoded byte
//   as each digit pair completes, and one success or error report per string
//   at the end marker or at the first bad character.
//   Throughput: one character per cycle, while no character with a result
//   waits on a held result; the state update between the input register and
//   the result register is combinational, and a character passes through
//   those two register stages in turn.
//   Characters that produce no result keep flowing while the result register
//   holds; a character with a result waits in the input register until the
//   held result is taken, and the text channel then stalls.
//   Reset clears the parser to the start of a string with a zero byte count
//   and empties both registers. Byte count saturates at 2^COUNT_BITS-1.
module hex_text_to_bytes import htb_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      text_valid,
  output logic      text_ready,
  input  htb_in_t   text,
  output logic      result_valid,
  input  logic      result_ready,
  output htb_out_t  result
);

  htb_state_t            state;
  htb_state_t            state_next;
  logic [COUNT_BITS-1:0] bytes_done;
  logic [COUNT_BITS-1:0] bytes_done_next;
  logic                  stage_valid;
  htb_in_t               stage_item;
  logic                  has_result;
  htb_out_t              step_result;
  logic                  out_free;
  logic                  advance;

  htb_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .state           (state),
    .bytes_done      (bytes_done),
    .item            (stage_item),
    .state_next      (state_next),
    .bytes_done_next (bytes_done_next),
    .has_result      (has_result),
    .result          (step_result)
  );

  assign out_free   = !result_valid || result_ready;
  assign advance    = stage_valid && (!has_result || out_free);
  assign text_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
      state        <= STATE_RESET;
      bytes_done   <= '0;
    end else begin
      if (text_ready) begin
        stage_valid <= text_valid;
      end
      if (advance) begin
        state      <= state_next;
        bytes_done <= bytes_done_next;
      end
      // load a new result, or hold one that is not taken yet
      result_valid <= (advance && has_result) || (result_valid && !result_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && text_ready) begin
      stage_item <= text;
    end
    if (advance && has_result) begin
      result <= step_result;
    end
  end

endmodule

@@ hw/rtl/htb_decode.sv @@
// htb_decode: next-state and result logic for one character of hex text.
// Depends on htb_pkg.
`timescale 1ns / 1ps

module htb_decode import htb_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  htb_state_t             state,
  input  logic [COUNT_BITS-1:0]  bytes_done,
  input  htb_in_t                item,
  output htb_state_t             state_next,
  output logic [COUNT_BITS-1:0]  bytes_done_next,
  output logic                   has_result,
  output htb_out_t               result
);

  logic [4:0]            hv;
  logic                  is_hex;
  logic [3:0]            nib;
  logic                  body;
  logic                  pend;
  logic [3:0]            hn;
  logic [COUNT_BITS-1:0] count_src;
  logic [15:0]           count16;

  assign hv     = hex_value(item.text_char);
  assign is_hex = hv[4];
  assign nib    = hv[3:0];

  // a held leading zero becomes the pending high nibble
  assign pend = (state.phase == PH_SAW_ZERO) ? 1'b1 : state.half_byte_pending;
  assign hn   = (state.phase == PH_SAW_ZERO) ? 4'd0 : state.high_nibble;

  always_comb begin
    state_next      = state;
    bytes_done_next = bytes_done;
    has_result      = 1'b0;
    result          = '0;
    body            = 1'b0;

    if (item.end_of_text) begin
      state_next      = STATE_RESET;
      bytes_done_next = '0;
      if (state.phase != PH_DROP) begin
        has_result = 1'b1;
        if (state.phase == PH_SAW_ZERO ||
            (state.phase == PH_BODY && state.half_byte_pending)) begin
          result.result_kind = KIND_ERROR;
          result.error_code  = ERR_UNPAIRED;
        end else if (state.in_braces) begin
          result.result_kind = KIND_ERROR;
          result.error_code  = ERR_BRACE;
        end else begin
          result.result_kind = KIND_DONE;
        end
      end
    end else begin
      unique case (state.phase)
        PH_START: begin
          if (item.text_char == CH_ZERO) begin
            state_next.phase = PH_SAW_ZERO;
          end else if (item.text_char == CH_LBRACE) begin
            state_next.in_braces = 1'b1;
            state_next.phase     = PH_BODY;
          end else begin
            body = 1'b1;
          end
        end
        PH_SAW_ZERO: begin
          if (item.text_char == CH_X) begin
            state_next.phase = PH_AFTER_PREFIX;
          end else begin
            body = 1'b1;
          end
        end
        PH_AFTER_PREFIX: begin
          if (item.text_char == CH_LBRACE) begin
            state_next.in_braces = 1'b1;
            state_next.phase     = PH_BODY;
          end else begin
            body = 1'b1;
          end
        end
        PH_BODY: body = 1'b1;
        PH_CLOSED: begin
          state_next.phase   = PH_DROP;
          has_result         = 1'b1;
          result.result_kind = KIND_ERROR;
          result.error_code  = ERR_TRAILING;
        end
        PH_DROP: state_next.phase = PH_DROP;
        default: state_next.phase = PH_DROP;
      endcase

      if (body) begin
        state_next.phase             = PH_BODY;
        state_next.half_byte_pending = pend;
        state_next.high_nibble       = hn;
        if (is_hex) begin
          if (pend) begin
            state_next.half_byte_pending = 1'b0;
            if (bytes_done != {COUNT_BITS{1'b1}}) begin
              bytes_done_next = bytes_done + 1'b1;
            end
            has_result         = 1'b1;
            result.result_kind = KIND_BYTE;
            result.data_byte   = {hn, nib};
          end else begin
            state_next.high_nibble       = nib;
            state_next.half_byte_pending = 1'b1;
          end
        end else if (state.in_braces && item.text_char == CH_RBRACE) begin
          state_next.in_braces = 1'b0;
          if (pend) begin
            state_next.phase   = PH_DROP;
            has_result         = 1'b1;
            result.result_kind = KIND_ERROR;
            result.error_code  = ERR_UNPAIRED;
          end else begin
            state_next.phase = PH_CLOSED;
          end
        end else begin
          state_next.phase   = PH_DROP;
          has_result         = 1'b1;
          result.result_kind = KIND_ERROR;
          result.error_code  = ERR_NON_HEX;
        end
      end
    end

    result.byte_count = count16;
  end

  // a byte reports the count after itself; everything else the count so far
  assign count_src = item.end_of_text ? bytes_done : bytes_done_next;

  generate
    if (COUNT_BITS >= 16) begin : g_wide
      assign count16 = count_src[15:0];
    end else begin : g_narrow
      assign count16 = {{(16 - COUNT_BITS){1'b0}}, count_src};
    end
  endgenerate

endmodule

@@ verif/htb_result_checker.sv @@
// htb_result_checker: predicts and checks the result stream of hex_text_to_bytes.
// Watches both channels of the block; depends on htb_pkg for payload types and codes.
`timescale 1ns / 1ps

module htb_result_checker import htb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     text_valid,
  input  logic     text_ready,
  input  htb_in_t  text,
  input  logic     result_valid,
  input  logic     result_ready,
  input  htb_out_t result,
  output int       fail_count,
  output int       expected_left
);

  // predicted decoder state
  htb_phase_t                    ph;
  logic                          braced;
  logic                          nib_pending;
  logic [3:0]                    hi_nib;
  logic [COUNT_BITS_DEFAULT-1:0] decoded_count;

  htb_out_t expected_q[$];

  function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;              // '0'..'9'
    else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h61 + 8'd10; // 'a'..'f'
    else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h41 + 8'd10; // 'A'..'F'
    else begin
      v = 4'd0;
      return 1'b0;
    end
    v = d[3:0];
    return 1'b1;
  endfunction

  task automatic push_report(input logic [1:0] kind, input logic [7:0] b,
                             input logic [2:0] err);
    htb_out_t r;
    r.result_kind = kind;
    r.data_byte   = b;
    r.byte_count  = 16'(decoded_count);
    r.error_code  = err;
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic clear_parser();
    ph            = PH_START;
    braced        = 1'b0;
    nib_pending   = 1'b0;
    hi_nib        = 4'd0;
    decoded_count = '0;
  endtask

  task automatic decode_body(input logic [7:0] c);
    logic       ok;
    logic [3:0] v;
    ok = hex_digit(c, v);
    ph = PH_BODY;
    if (ok) begin
      if (nib_pending) begin
        nib_pending = 1'b0;
        // count saturates
        if (decoded_count != '1) decoded_count = decoded_count + 1'b1;
        push_report(KIND_BYTE, {hi_nib, v}, ERR_NONE);
      end else begin
        hi_nib      = v;
        nib_pending = 1'b1;
      end
    end else if (braced && c == CH_RBRACE) begin
      braced = 1'b0;
      if (nib_pending) begin
        ph = PH_DROP;
        push_report(KIND_ERROR, 8'd0, ERR_UNPAIRED);
      end else begin
        ph = PH_CLOSED;
      end
    end else begin
      ph = PH_DROP;
      push_report(KIND_ERROR, 8'd0, ERR_NON_HEX);
    end
  endtask

  task automatic predict_char(input logic [7:0] c, input logic eot);
    if (eot) begin
      if (ph == PH_DROP) begin
        // silent restart
      end else if (ph == PH_SAW_ZERO || (ph == PH_BODY && nib_pending)) begin
        push_report(KIND_ERROR, 8'd0, ERR_UNPAIRED);
      end else if (braced) begin
        push_report(KIND_ERROR, 8'd0, ERR_BRACE);
      end else begin
        push_report(KIND_DONE, 8'd0, ERR_NONE);
      end
      clear_parser();
    end else begin
      case (ph)
        PH_START: begin
          if (c == CH_ZERO) ph = PH_SAW_ZERO;
          else if (c == CH_LBRACE) begin
            braced = 1'b1;
            ph     = PH_BODY;
          end else decode_body(c);
        end
        PH_SAW_ZERO: begin
          if (c == CH_X) ph = PH_AFTER_PREFIX;
          else begin
            // held zero turns into a pending high nibble
            hi_nib      = 4'd0;
            nib_pending = 1'b1;
            decode_body(c);
          end
        end
        PH_AFTER_PREFIX: begin
          if (c == CH_LBRACE) begin
            braced = 1'b1;
            ph     = PH_BODY;
          end else decode_body(c);
        end
        PH_BODY: decode_body(c);
        PH_CLOSED: begin
          ph = PH_DROP;
          push_report(KIND_ERROR, 8'd0, ERR_TRAILING);
        end
        default: ph = PH_DROP;
      endcase
    end
  endtask

  always @(posedge clk) begin
    htb_out_t want;
    if (rst) begin
      clear_parser();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (text_valid && text_ready) predict_char(text.text_char, text.end_of_text);
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: kind %0d byte %h count %0d error %0d",
                 result.result_kind, result.data_byte, result.byte_count, result.error_code);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (result.result_kind !== want.result_kind) begin
            $error("result_kind expected %0d actual %0d", want.result_kind, result.result_kind);
            fail_count++;
          end
          if (result.data_byte !== want.data_byte) begin
            $error("data_byte expected %h actual %h", want.data_byte, result.data_byte);
            fail_count++;
          end
          if (result.byte_count !== want.byte_count) begin
            $error("byte_count expected %0d actual %0d", want.byte_count, result.byte_count);
            fail_count++;
          end
          if (result.error_code !== want.error_code) begin
            $error("error_code expected %0d actual %0d", want.error_code, result.error_code);
            fail_count++;
          end
        end
      end
    end
    expected_left = expected_q.size();
  end

endmodule

@@ verif/testbench.sv @@
// testbench: stimulus and verdict for hex_text_to_bytes.
// Depends on htb_pkg, the block itself and htb_result_checker.
`timescale 1ns / 1ps

module testbench;
  import htb_pkg::*;

  localparam int TEXT_ITEMS     = 1650;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  logic     clk          = 1'b0;
  logic     rst          = 1'b1;
  logic     text_valid   = 1'b0;
  logic     text_ready;
  htb_in_t  text         = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  htb_out_t result;

  int   fail_count;
  int   expected_left;
  int   quiet_cycles = 0;
  int   counted      = 0;
  logic calm         = 1'b0;
  logic drained_once = 1'b0;

  logic [7:0] txt_buf[$];

  hex_text_to_bytes dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text         (text),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  htb_result_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_ready    (text_ready),
    .text          (text),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    result_ready <= calm || ($urandom_range(99) >= 23);
  end

  // end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((text_valid && text_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_char(input logic [7:0] c, input logic eot);
    while (!calm && $urandom_range(99) < 23) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text       <= '{text_char: c, end_of_text: eot};
    do @(posedge clk); while (!text_ready);
    @(negedge clk);
  endtask

  task automatic send_buffer();
    foreach (txt_buf[i]) send_char(txt_buf[i], 1'b0);
    send_char(8'($urandom_range(255)), 1'b1);
    counted += txt_buf.size() + 1;
    txt_buf.delete();
  endtask

  task automatic append_char(input logic [7:0] c);
    txt_buf.insert(txt_buf.size(), c);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endtask

  task automatic wait_drained();
    text_valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_digit();
    logic [7:0] v;
    v = 8'($urandom_range(15));
    if (v < 8'd10) return 8'h30 + v;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  // steering characters mixed with hex digits and arbitrary bytes
  function automatic logic [7:0] rand_special();
    case ($urandom_range(5))
      0:       return CH_ZERO;
      1:       return CH_X;
      2:       return CH_LBRACE;
      3:       return CH_RBRACE;
      4:       return rand_digit();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic build_well_formed();
    logic braced;
    int   pairs;
    braced = 1'($urandom_range(1));
    pairs  = $urandom_range(6);
    if ($urandom_range(1)) add_text("0x");
    if (braced) append_char(CH_LBRACE);
    repeat (2 * pairs) append_char(rand_digit());
    if ($urandom_range(9) == 0) append_char(rand_digit());
    if (braced && $urandom_range(9) != 0) append_char(CH_RBRACE);
    if ($urandom_range(19) == 0) append_char(rand_special());
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed strings
    send_buffer();                                      // empty string
    add_text("0");        send_buffer();                // lone zero
    add_text("0x");       send_buffer();                // prefix alone
    add_text("05");       send_buffer();                // held zero becomes high nibble
    add_text("0{");       send_buffer();                // brace after held zero
    add_text("0x{fF}");   send_buffer();
    add_text("{a}");      send_buffer();                // close brace with pending nibble
    add_text("}");        send_buffer();                // close brace, not braced
    add_text("{{");       send_buffer();                // second open brace
    append_char(8'h00);   send_buffer();                // NUL
    append_char(8'hFF);   send_buffer();
    add_text("{}z");      send_buffer();                // trailing character
    add_text("{");        send_buffer();                // unpaired brace
    add_text("0x3");      send_buffer();                // odd digit count at end

    // random strings: mostly well formed, some broken, some noise
    while (counted < TEXT_ITEMS) begin
      calm <= (counted >= 700 && counted < 900);
      case ($urandom_range(19)) inside
        [0:13]: begin
          build_well_formed();
          send_buffer();
        end
        [14:16]: begin
          build_well_formed();
          if (txt_buf.size() > 0 && $urandom_range(1))
            txt_buf[$urandom_range(txt_buf.size() - 1)] = rand_special();
          else
            txt_buf.insert($urandom_range(txt_buf.size()), rand_special());
          send_buffer();
        end
        default: begin
          repeat ($urandom_range(1, 6)) append_char(rand_special());
          send_buffer();
        end
      endcase
      if (!drained_once && counted >= 1000) begin
        drained_once = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
